### rtl/core/bfns_pkg.sv
// Package for the bitmap next-set-bit search block: request and response
// transaction types, field widths, request codes and default sizes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bfns_pkg;

  // Fixed field widths of the transactions
  localparam int IDX_W  = 6;
  localparam int DATA_W = 64;
  localparam int POS_W  = 13;
  localparam int LSB_W  = 6;

  // Default geometry
  localparam int WORDS_DEF     = 64;
  localparam int WORD_BITS_DEF = 64;

  // Request codes
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [IDX_W-1:0]  word_index;
    logic [DATA_W-1:0] word_data;
    logic [POS_W-1:0]  search_size;
    logic [POS_W-1:0]  start_offset;
  } req_t;

  typedef struct packed {
    logic [POS_W-1:0] found_position;
    logic             none_found;
  } rsp_t;

endpackage

`default_nettype wire

### rtl/core/bfns_mem.sv
// Bitmap word store: one write port, one read port, registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module bfns_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/bfns_lsb.sv
// Lowest-set-bit encoder over one bitmap word, six halving steps.
// Depends on bfns_pkg for the word and index widths.
`timescale 1ns / 1ps
`default_nettype none

module bfns_lsb (
  input  wire logic [bfns_pkg::DATA_W-1:0] word,
  output      logic [bfns_pkg::LSB_W-1:0]  idx
);

  import bfns_pkg::*;

  logic [DATA_W-1:0] t1, t2, t3, t4, t5;

  // Each step checks the low half of what is left and drops it when empty.
  always_comb begin
    idx[5] = (word[31:0] == 32'h0);
    t1     = idx[5] ? (word >> 32) : word;
    idx[4] = (t1[15:0] == 16'h0);
    t2     = idx[4] ? (t1 >> 16) : t1;
    idx[3] = (t2[7:0] == 8'h0);
    t3     = idx[3] ? (t2 >> 8) : t2;
    idx[2] = (t3[3:0] == 4'h0);
    t4     = idx[2] ? (t3 >> 4) : t3;
    idx[1] = (t4[1:0] == 2'h0);
    t5     = idx[1] ? (t4 >> 2) : t4;
    idx[0] = ~t5[0];
  end

endmodule

`default_nettype wire

### rtl/core/bfns_seq.sv
// Request sequencer: takes writes into the word store, and walks the store
// one word per cycle for a search. Depends on bfns_pkg and bfns_lsb.
`timescale 1ns / 1ps
`default_nettype none

module bfns_seq #(
  parameter int WORDS     = bfns_pkg::WORDS_DEF,
  parameter int WORD_BITS = bfns_pkg::WORD_BITS_DEF,
  parameter int AW        = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire bfns_pkg::req_t       req,
  output      logic                 busy,
  output      logic                 done,
  output      bfns_pkg::rsp_t       rsp,
  output      logic                 mem_we,
  output      logic [AW-1:0]        mem_waddr,
  output      logic [WORD_BITS-1:0] mem_wdata,
  output      logic [AW-1:0]        mem_raddr,
  input  wire logic [WORD_BITS-1:0] mem_rdata
);

  import bfns_pkg::*;

  // Offset split into word and bit: multiply by a scaled reciprocal, then
  // one compare and subtract fixes the quotient, which can be one short.
  localparam int SHIFT  = 20;
  localparam int RECIP  = (1 << SHIFT) / WORD_BITS;
  localparam int RW     = $clog2(RECIP + 1);
  localparam int PROD_W = POS_W + RW;
  localparam int QW     = $clog2(((1 << POS_W) - 1) / WORD_BITS + 2);
  localparam int BW     = $clog2(WORD_BITS);
  localparam int BASE_W = POS_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_COR,
    S_SCAN,
    S_PICK
  } state_t;

  state_t               state;
  logic [POS_W-1:0]     size;
  logic [POS_W-1:0]     off;
  logic [PROD_W-1:0]    prod;
  logic [QW-1:0]        w;
  logic [BASE_W-1:0]    base;
  logic [BW-1:0]        bitoff;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] hit_v;
  logic                 primed;

  logic [QW-1:0]        q_est;
  logic [BASE_W-1:0]    base_est;
  logic [BASE_W-1:0]    r_est;
  logic                 r_over;
  logic [QW-1:0]        q_fix;
  logic [BASE_W-1:0]    base_fix;
  logic [BW-1:0]        r_fix;
  logic [QW+AW-1:0]     w_ext;
  logic                 w_out;
  logic [WORD_BITS-1:0] v;
  logic                 hit;
  logic [BASE_W-1:0]    base_next;
  logic                 past_size;
  logic [LSB_W-1:0]     lsb_idx;
  logic [BASE_W-1:0]    pos;

  bfns_lsb u_lsb (
    .word (DATA_W'(hit_v)),
    .idx  (lsb_idx)
  );

  always_comb begin
    q_est     = QW'(prod >> SHIFT);
    base_est  = BASE_W'(q_est * WORD_BITS);
    r_est     = BASE_W'(off) - base_est;
    r_over    = (r_est >= BASE_W'(WORD_BITS));
    q_fix     = r_over ? (q_est + QW'(1)) : q_est;
    base_fix  = r_over ? (base_est + BASE_W'(WORD_BITS)) : base_est;
    r_fix     = r_over ? BW'(r_est - BASE_W'(WORD_BITS)) : BW'(r_est);
    w_ext     = (QW + AW)'(w);
    w_out     = (32'(w) >= WORDS);
    v         = mem_rdata & mask;
    hit       = (v != '0);
    base_next = base + BASE_W'(WORD_BITS);
    past_size = (base_next >= BASE_W'(size));
    pos       = base + BASE_W'(lsb_idx);
  end

  // Writes go straight to the store; busy keeps them out of a search, so a
  // read never overlaps a write to the same word.
  assign mem_we    = (state == S_IDLE) && start && (req.req_type == REQ_WRITE)
                     && (32'(req.word_index) < WORDS);
  assign mem_waddr = AW'(req.word_index);
  assign mem_wdata = req.word_data[WORD_BITS-1:0];
  assign mem_raddr = w_ext[AW-1:0];
  assign busy      = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      primed <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start && (req.req_type == REQ_SEARCH)) begin
            size <= req.search_size;
            off  <= req.start_offset;
            if (req.start_offset >= req.search_size) begin
              rsp.found_position <= req.search_size;
              rsp.none_found     <= 1'b1;
              done               <= 1'b1;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          prod  <= PROD_W'(32'(off) * RECIP);
          state <= S_COR;
        end
        S_COR: begin
          w      <= q_fix;
          base   <= base_fix;
          bitoff <= r_fix;
          primed <= 1'b0;
          state  <= S_SCAN;
        end
        S_SCAN: begin
          if (!primed) begin
            // First read issued this cycle; build the mask below the offset.
            if (w_out) begin
              rsp.found_position <= size;
              rsp.none_found     <= 1'b1;
              done               <= 1'b1;
              state              <= S_IDLE;
            end else begin
              mask   <= {WORD_BITS{1'b1}} << bitoff;
              w      <= w + QW'(1);
              primed <= 1'b1;
            end
          end else if (hit) begin
            hit_v <= v;
            state <= S_PICK;
          end else if (past_size || w_out) begin
            rsp.found_position <= size;
            rsp.none_found     <= 1'b1;
            done               <= 1'b1;
            state              <= S_IDLE;
          end else begin
            base <= base_next;
            mask <= {WORD_BITS{1'b1}};
            w    <= w + QW'(1);
          end
        end
        S_PICK: begin
          if (pos >= BASE_W'(size)) begin
            rsp.found_position <= size;
            rsp.none_found     <= 1'b1;
          end else begin
            rsp.found_position <= POS_W'(pos);
            rsp.none_found     <= 1'b0;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/bitmap_find_next_set_bit_top.sv
// Top level of the bitmap next-set-bit search block: word store plus
// request sequencer. Depends on bfns_pkg, bfns_mem, bfns_seq.
//
// Channel   Direction  Handshake              Payload
// request   in         start high, busy low   req  (bfns_pkg::req_t)
// result    out        done high, one cycle   rsp  (bfns_pkg::rsp_t)
//
// A write transaction stores one word in the cycle it is accepted, gives no
// result and leaves busy low, so another transaction may follow at once.
// A search whose offset is at or past its length reports in the cycle after it is accepted.
// Any other search splits its offset (S_DIV, S_COR), walks the words (S_SCAN)
// and, when a walked word holds a set bit, picks that bit (S_PICK) before it
// reports. The walk covers no word when the offset word lies past the store,
// else one up to WORDS words, read through the single read port of the
// store one word per cycle; busy stays high meanwhile.
// Reset is synchronous and clears control state only; the store holds no
// defined value until written. The receiver cannot stall: done is a
// one-cycle strobe.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_find_next_set_bit_top #(
  parameter int WORDS     = bfns_pkg::WORDS_DEF,
  parameter int WORD_BITS = bfns_pkg::WORD_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire bfns_pkg::req_t req,
  output      logic           busy,
  output      logic           done,
  output      bfns_pkg::rsp_t rsp
);

  import bfns_pkg::*;

  // Word address width of the store; a single-word store still gets one bit.
  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  // Bitmap words, with registered read data.
  bfns_mem #(
    .DEPTH (WORDS),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Decode transactions, split the offset, walk the words, pick the bit.
  bfns_seq #(
    .WORDS     (WORDS),
    .WORD_BITS (WORD_BITS),
    .AW        (AW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .busy      (busy),
    .done      (done),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

`default_nettype wire

### tb/sv/bitmap_find_next_set_bit_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_find_next_set_bit_top: a queued driver of write
// and search transactions, a shadow copy of the bitmap that predicts every search
// result, and a monitor that checks each done strobe. Depends on bfns_pkg and the RTL.

module bitmap_find_next_set_bit_top_tb;
  import bfns_pkg::*;

  typedef struct {
    req_t r;
    bit   drain;  // hold this transaction back until no result is outstanding
  } queued_req_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  bitmap_find_next_set_bit_top dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  queued_req_t       request_backlog[$];
  rsp_t              predicted_finds[$];
  logic [DATA_W-1:0] bitmap_copy[WORDS_DEF];
  rsp_t              oldest_find;
  rsp_t              new_find;
  int                fail_count = 0;
  int                accepted_count = 0;
  int                writes_taken = 0;
  int                searches_taken = 0;
  int                results_checked = 0;
  int                empty_ranges = 0;

  // Free-running clock, 10 ns period
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Lowest set bit of the shadow bitmap at or after off and below size; size when
  // there is none. Walk word by word from the word holding off, masking that first
  // word below off; positions past the stored bitmap read as zero.
  function automatic logic [POS_W-1:0] next_set_pos(input logic [POS_W-1:0] size,
                                                    input logic [POS_W-1:0] off);
    int unsigned       w;
    int unsigned       b;
    int unsigned       pos;
    logic [DATA_W-1:0] v;
    if (off >= size) return size;
    for (w = off / WORD_BITS_DEF; w * WORD_BITS_DEF < size; w++) begin
      v = (w < WORDS_DEF) ? bitmap_copy[w] : '0;
      if (w == off / WORD_BITS_DEF) v &= {DATA_W{1'b1}} << (off % WORD_BITS_DEF);
      for (b = 0; b < WORD_BITS_DEF; b++) begin
        if (v[b]) begin
          pos = w * WORD_BITS_DEF + b;
          return (pos < size) ? pos[POS_W-1:0] : size;
        end
      end
    end
    return size;
  endfunction

  // Mostly empty or sparse words, so that searches walk far; some dense ones too.
  function automatic logic [DATA_W-1:0] sparse_word();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 45) return '0;
    if (k < 75) return 64'h1 << $urandom_range(63);
    if (k < 83) return (64'h1 << $urandom_range(63)) | (64'h1 << $urandom_range(63));
    if (k < 88) return {DATA_W{1'b1}};
    return {$urandom, $urandom};
  endfunction

  task automatic queue_write(input int idx, input logic [DATA_W-1:0] data);
    queued_req_t q;
    q.r.req_type     = REQ_WRITE;
    q.r.word_index   = idx[IDX_W-1:0];
    q.r.word_data    = data;
    // search fields are don't-care on a write; toggle them anyway
    q.r.search_size  = POS_W'($urandom_range(4096));
    q.r.start_offset = POS_W'($urandom_range(4096));
    q.drain          = 1'b0;
    request_backlog.push_back(q);
  endtask

  task automatic queue_search(input int size, input int off, input bit drain);
    queued_req_t q;
    q.r.req_type     = REQ_SEARCH;
    q.r.word_index   = IDX_W'($urandom_range(63));
    q.r.word_data    = {$urandom, $urandom};
    q.r.search_size  = POS_W'(size);
    q.r.start_offset = POS_W'(off);
    q.drain          = drain;
    request_backlog.push_back(q);
  endtask

  // Driver: present one transaction at a time and hold it until start && !busy
  // takes it at a rising edge. Record the accepted transaction in the shadow
  // bitmap, or queue its predicted result. Idle at random, except in a long
  // stretch in the middle of the run.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      req   <= '0;
    end else begin
      if (start && !busy) begin
        accepted_count++;
        if (req.req_type == REQ_WRITE) begin
          bitmap_copy[req.word_index] = req.word_data;
          writes_taken++;
        end else begin
          new_find.found_position = next_set_pos(req.search_size, req.start_offset);
          new_find.none_found     = (new_find.found_position == req.search_size);
          predicted_finds.push_back(new_find);
          searches_taken++;
        end
      end
      if (start && busy) begin
        // hold the presented transaction
      end else if (request_backlog.size() != 0
                   && !(request_backlog[0].drain && predicted_finds.size() != 0)
                   && ((accepted_count >= 900 && accepted_count < 1400)
                       || $urandom_range(99) >= 12)) begin
        start <= 1'b1;
        req   <= request_backlog[0].r;
        request_backlog.delete(0);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: done is a one-cycle strobe; match it against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (predicted_finds.size() == 0) begin
        $error("unexpected result: found_position %0d, none_found %0b",
               rsp.found_position, rsp.none_found);
        fail_count++;
      end else begin
        oldest_find = predicted_finds.pop_front();
        results_checked++;
        if (oldest_find.none_found) empty_ranges++;
        if (rsp.found_position !== oldest_find.found_position) begin
          $error("found_position: expected %0d, actual %0d",
                 oldest_find.found_position, rsp.found_position);
          fail_count++;
        end
        if (rsp.none_found !== oldest_find.none_found) begin
          $error("none_found: expected %0b, actual %0b",
                 oldest_find.none_found, rsp.none_found);
          fail_count++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int size;
    int off;
    int k;
    int span;

    // Fill every word first: the store is undefined until written, and a search
    // must never walk into a word that was never written.
    for (int i = 0; i < WORDS_DEF; i++) queue_write(i, sparse_word());

    // Directed: known words at both ends of the bitmap, then edge searches.
    queue_write(0, 64'h1);
    queue_write(1, 64'h0);
    queue_write(2, {DATA_W{1'b1}});
    queue_write(62, 64'h0);
    queue_write(63, 64'h8000_0000_0000_0000);
    queue_search(0, 0, 1'b0);         // empty range
    queue_search(4096, 0, 1'b0);      // bit 0 of the first word
    queue_search(4096, 1, 1'b0);      // first word masked, skip an empty word
    queue_search(1, 0, 1'b0);         // one-bit range
    queue_search(64, 1, 1'b0);        // nothing left in the first word
    queue_search(4096, 4095, 1'b0);   // top bit of the last word
    queue_search(4095, 4000, 1'b0);   // only set bit lies past the length
    queue_search(4096, 4096, 1'b0);   // offset equals length
    queue_search(100, 4096, 1'b0);    // offset past length
    queue_search(130, 129, 1'b0);     // mid-word offset in a full word
    queue_search(128, 65, 1'b1);      // stop at the word boundary; wait to drain first
    queue_search(4096, 3968, 1'b0);   // last two words only

    // Random mix: about a third writes, the rest searches of varied length and
    // offset, with offsets mostly inside the range.
    for (int i = 0; i < 2000; i++) begin
      if ($urandom_range(99) < 30) begin
        queue_write($urandom_range(63), sparse_word());
      end else begin
        k = $urandom_range(99);
        if (k < 25) size = 4096;
        else if (k < 55) size = $urandom_range(4096);
        else if (k < 75) size = $urandom_range(200);
        else size = 64 * $urandom_range(64) + $urandom_range(2) - 1;
        if (size < 0) size = 0;
        if (size > 4096) size = 4096;
        k = $urandom_range(99);
        if (k < 10 || size == 0) begin
          off = $urandom_range(4096, size);
        end else if (k < 55) begin
          off = $urandom_range(size - 1);
        end else if (k < 80) begin
          span = (size - 1 < 130) ? size - 1 : 130;
          off  = $urandom_range(span);
        end else begin
          span = (size - 1 < 70) ? size - 1 : 70;
          off  = size - 1 - $urandom_range(span);
        end
        queue_search(size, off, (i == 700 || i == 1600));
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Drain: all transactions taken, all results in, then a margin beyond the
    // longest search so any stray strobe is caught.
    while (request_backlog.size() != 0 || start) @(posedge clk);
    while (predicted_finds.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Accepted %0d word writes and %0d searches over a fully written bitmap.",
             writes_taken, searches_taken);
    $display("Checked %0d search results, %0d of them with no set bit in range.",
             results_checked, empty_ranges);
    if (fail_count == 0) begin
      $display("bitmap_find_next_set_bit_top: match");
    end else begin
      $display("bitmap_find_next_set_bit_top: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("bitmap_find_next_set_bit_top: mismatch");
    $finish;
  end

endmodule
